[rtl/owpw_pkg.sv]
// Shared types, constants and helpers for the one-wire pulse-width byte sender.
`default_nettype none

package owpw_pkg;

  // Width of the phase tick counter
  localparam int TIMER_WIDTH = 16;

  // Configuration register file
  localparam int NUM_REGS  = 7;
  localparam int REG_WIDTH = 16;
  localparam int IDX_WIDTH = 3;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_START_HIGH = 3'd0,
    REG_ZERO_LOW   = 3'd1,
    REG_ZERO_HIGH  = 3'd2,
    REG_ONE_LOW    = 3'd3,
    REG_ONE_HIGH   = 3'd4,
    REG_END_LOW    = 3'd5,
    REG_END_HIGH   = 3'd6
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] cfg_regs_t;

  localparam cfg_regs_t REG_RESET_VALS = {
    16'd400,  // end_high_ticks
    16'd4,    // end_low_ticks
    16'd12,   // one_high_ticks
    16'd4,    // one_low_ticks
    16'd4,    // zero_high_ticks
    16'd12,   // zero_low_ticks
    16'd15    // start_high_ticks
  };

  // Request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Bits per frame
  localparam logic [3:0] FRAME_BITS = 4'd8;

  // Frame phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_BIT_LOW  = 3'd2,
    PH_BIT_HIGH = 3'd3,
    PH_END_LOW  = 3'd4,
    PH_END_HIGH = 3'd5
  } phase_t;

  // Input word
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic load_rejected;
  } out_word_t;

  // Register value cut or zero-extended to the timer width
  function automatic logic [TIMER_WIDTH-1:0] to_timer(input logic [REG_WIDTH-1:0] v);
    logic [31:0] wide;
    wide = {16'b0, v};
    return wide[TIMER_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/owpw_regs.sv]
// Configuration register file of the pulse-width byte sender.
`default_nettype none

module owpw_regs
  import owpw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [IDX_WIDTH-1:0] wr_index,
  input  wire logic [REG_WIDTH-1:0] wr_data,
  output cfg_regs_t                 regs
);

  // Writes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET_VALS;
    end else if (wr_en && (32'(wr_index) < NUM_REGS)) begin
      regs[wr_index] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/owpw_core.sv]
// Frame sequencer: phase, bit and tick state, one word handled per cycle while step is high.
`default_nettype none

module owpw_core
  import owpw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_regs_t regs,
  input  wire logic      step,
  input  wire in_word_t  word,
  output out_word_t      result
);

  phase_t                 phase, phase_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [3:0]             bits_left, bits_left_next;
  logic [TIMER_WIDTH-1:0] ticks_left, ticks_left_next;
  logic                   line_reg, line_reg_next;

  logic [3:0] bits_dec;
  logic       done;
  logic       rejected;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift_reg  <= '0;
      bits_left  <= '0;
      ticks_left <= '0;
      line_reg   <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      shift_reg  <= shift_reg_next;
      bits_left  <= bits_left_next;
      ticks_left <= ticks_left_next;
      line_reg   <= line_reg_next;
    end
  end

  assign bits_dec = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;

  // Next state and result for the current word
  always_comb begin
    phase_next      = phase;
    shift_reg_next  = shift_reg;
    bits_left_next  = bits_left;
    ticks_left_next = ticks_left;
    line_reg_next   = line_reg;
    done            = 1'b0;
    rejected        = 1'b0;

    if (word.req_type == REQ_LOAD) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        shift_reg_next  = word.data_byte;
        bits_left_next  = FRAME_BITS;
        phase_next      = PH_START;
        ticks_left_next = to_timer(regs[REG_START_HIGH]);
        line_reg_next   = 1'b1;
      end
    end else if (phase != PH_IDLE) begin
      if (ticks_left > TIMER_WIDTH'(1)) begin
        ticks_left_next = ticks_left - TIMER_WIDTH'(1);
      end else begin
        // Phase used up: move on
        case (phase)
          PH_START: begin
            phase_next      = PH_BIT_LOW;
            ticks_left_next = to_timer(shift_reg[7] ? regs[REG_ONE_LOW]
                                                    : regs[REG_ZERO_LOW]);
            line_reg_next   = 1'b0;
          end
          PH_BIT_LOW: begin
            phase_next      = PH_BIT_HIGH;
            ticks_left_next = to_timer(shift_reg[7] ? regs[REG_ONE_HIGH]
                                                    : regs[REG_ZERO_HIGH]);
            line_reg_next   = 1'b1;
          end
          PH_BIT_HIGH: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bits_left_next = bits_dec;
            line_reg_next  = 1'b0;
            if (bits_dec == 4'd0) begin
              phase_next      = PH_END_LOW;
              ticks_left_next = to_timer(regs[REG_END_LOW]);
            end else begin
              phase_next      = PH_BIT_LOW;
              ticks_left_next = to_timer(shift_reg[6] ? regs[REG_ONE_LOW]
                                                      : regs[REG_ZERO_LOW]);
            end
          end
          PH_END_LOW: begin
            phase_next      = PH_END_HIGH;
            ticks_left_next = to_timer(regs[REG_END_HIGH]);
            line_reg_next   = 1'b1;
          end
          PH_END_HIGH: begin
            phase_next      = PH_IDLE;
            ticks_left_next = '0;
            line_reg_next   = 1'b1;
            done            = 1'b1;
          end
          default: begin
            phase_next      = PH_IDLE;
            ticks_left_next = '0;
          end
        endcase
      end
    end

    result.line_level    = line_reg_next;
    result.busy_res      = (phase_next != PH_IDLE);
    result.frame_done    = done;
    result.load_rejected = rejected;
  end

endmodule

`default_nettype wire

[rtl/one_wire_pulse_width_byte_sender_top.sv]
// Top level of the one-wire pulse-width byte sender: handshakes and result buffer.
//
// Usage:
//   in channel (in_valid/in_ready/in_word): each word is a tick (req_type 0)
//   or a byte load (req_type 1). Every accepted word yields exactly one
//   result word on the out channel (out_valid/out_ready/out_word) carrying
//   the line level, busy flag, frame-done pulse and load-rejected flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one of the
//   seven timing registers; cfg_ready is always high, and indexes past the
//   last register are dropped. Write only while no result is outstanding.
// Results: each result is registered into the output or the skid register.
// Throughput: one word per cycle while in_ready is high; the sequencer state
//   updates in the cycle of acceptance, so a word may follow in the next cycle.
// Stall: a two-entry result buffer (output register plus skid register)
//   keeps in_ready high for one more word while a result waits; in_ready
//   drops only when both entries are full.
// Reset: timing registers return to their defaults, the sequencer goes idle
//   with the line low, and the result buffer empties.
`default_nettype none

module one_wire_pulse_width_byte_sender_top
  import owpw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IDX_WIDTH-1:0] cfg_index,
  input  wire logic [REG_WIDTH-1:0] cfg_data
);

  cfg_regs_t regs;
  out_word_t result;
  out_word_t skid_word;
  logic      skid_valid;
  logic      accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  owpw_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  owpw_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .step   (accept),
    .word   (in_word),
    .result (result)
  );

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result buffer data
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= result;
      end
    end else if (accept) begin
      skid_word <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/owpw_checker.sv]
// Port-level checks of the pulse-width byte sender and their binding.
`default_nettype none

module owpw_checker
  import owpw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // After an accepted word, out_valid is always high in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // End of frame leaves the line high and the sender idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_done |-> out_word.line_level && !out_word.busy_res)
    else $error("frame done while busy or line low");

  // A rejected load only happens while a frame is running
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.load_rejected |-> out_word.busy_res && !out_word.frame_done)
    else $error("load rejected while idle");

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result buffer not empty after reset");

endmodule

bind one_wire_pulse_width_byte_sender_top owpw_checker u_owpw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire

[sim/tb_one_wire_pulse_width_byte_sender_top.sv]
// Self-checking testbench for the one-wire pulse-width byte sender top level.
module tb_one_wire_pulse_width_byte_sender_top;
  timeunit 1ns;
  timeprecision 1ps;

  import owpw_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int WIDE_TICKS   = 8;
  localparam logic [IDX_WIDTH-1:0] BAD_IDX = IDX_WIDTH'(NUM_REGS);

  // Tracks the frame sequencer and holds the result words still owed
  class frame_tracker;
    logic [REG_WIDTH-1:0]   timing [NUM_REGS];
    logic [7:0]             shift_byte;
    logic [3:0]             bits_to_go;
    phase_t                 phase;
    logic [TIMER_WIDTH-1:0] ticks_to_go;
    logic                   level;
    out_word_t              owed_words[$];
    int                     errors;

    function new();
      for (int i = 0; i < NUM_REGS; i++) timing[i] = REG_RESET_VALS[i];
      shift_byte  = '0;
      bits_to_go  = '0;
      phase       = PH_IDLE;
      ticks_to_go = '0;
      level       = 1'b0;
      errors      = 0;
    endfunction

    function void set_timing(logic [IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
      // out-of-range index is dropped
      if (idx < NUM_REGS) timing[idx] = val;
    endfunction

    function void enter(phase_t ph, int idx, logic lvl);
      phase       = ph;
      ticks_to_go = TIMER_WIDTH'(timing[idx]);
      level       = lvl;
    endfunction

    function int low_reg();
      return shift_byte[7] ? REG_ONE_LOW : REG_ZERO_LOW;
    endfunction

    function int high_reg();
      return shift_byte[7] ? REG_ONE_HIGH : REG_ZERO_HIGH;
    endfunction

    // Step to the following phase; returns 1 when the frame completes
    function logic next_phase();
      case (phase)
        PH_START: enter(PH_BIT_LOW, low_reg(), 1'b0);
        PH_BIT_LOW: enter(PH_BIT_HIGH, high_reg(), 1'b1);
        PH_BIT_HIGH: begin
          shift_byte = shift_byte << 1;
          if (bits_to_go > 0) bits_to_go--;
          if (bits_to_go == 0) enter(PH_END_LOW, REG_END_LOW, 1'b0);
          else enter(PH_BIT_LOW, low_reg(), 1'b0);
        end
        PH_END_LOW: enter(PH_END_HIGH, REG_END_HIGH, 1'b1);
        PH_END_HIGH: begin
          phase       = PH_IDLE;
          ticks_to_go = '0;
          level       = 1'b1;
          return 1'b1;
        end
        default: begin
          phase       = PH_IDLE;
          ticks_to_go = '0;
        end
      endcase
      return 1'b0;
    endfunction

    // Accepted input word: advance the sequencer and queue the result it owes
    function void note_word(in_word_t w);
      out_word_t e;
      e = '0;
      if (w.req_type == REQ_LOAD) begin
        if (phase != PH_IDLE) begin
          e.load_rejected = 1'b1;
        end else begin
          shift_byte = w.data_byte;
          bits_to_go = FRAME_BITS;
          enter(PH_START, REG_START_HIGH, 1'b1);
        end
      end else if (phase != PH_IDLE) begin
        // zero count behaves like one tick
        if (ticks_to_go <= 1) e.frame_done = next_phase();
        else ticks_to_go--;
      end
      e.line_level = level;
      e.busy_res   = (phase != PH_IDLE);
      owed_words.push_back(e);
    endfunction

    function void compare(string name, logic want, logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %b, got %b", $time, name, want, got);
      end
    endfunction

    // Accepted result word: match it against the oldest owed word
    function void check_word(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        errors++;
        $display("%0t: result word %b with none expected", $time, got);
        return;
      end
      want = owed_words.pop_front();
      compare("line_level", want.line_level, got.line_level);
      compare("busy_res", want.busy_res, got.busy_res);
      compare("frame_done", want.frame_done, got.frame_done);
      compare("load_rejected", want.load_rejected, got.load_rejected);
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  in_word_t             in_word   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index = '0;
  logic [REG_WIDTH-1:0] cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  out_word_t            out_word;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycles         = 0;

  frame_tracker tracker = new();

  one_wire_pulse_width_byte_sender_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted words, stall at random or hold off on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_word(out_word);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one word, with an optional random gap first; valid stays up on return
  task automatic send_word(input in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w);
  endtask

  task automatic send_tick();
    in_word_t w;
    w.req_type  = REQ_TICK;
    w.data_byte = 8'($urandom_range(255));
    send_word(w);
  endtask

  task automatic send_load(input logic [7:0] b);
    in_word_t w;
    w.req_type  = REQ_LOAD;
    w.data_byte = b;
    send_word(w);
  endtask

  task automatic finish_frame();
    while (tracker.busy()) send_tick();
  endtask

  // Stop offering and wait until every owed result word has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_timing(idx, val);
  endtask

  // All timing registers random in [lo, hi], plus one write past the last index
  task automatic set_timing_regs(input int lo, input int hi);
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(IDX_WIDTH'(i), REG_WIDTH'($urandom_range(hi, lo)));
    end
    write_reg(BAD_IDX, REG_WIDTH'($urandom_range(65535)));
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete frames; a few loads land while busy and get rejected
  task automatic run_random(input int n_items);
    repeat (n_items) begin
      if (tracker.busy()) begin
        if ($urandom_range(99) < 6) send_load(8'($urandom_range(255)));
        else send_tick();
      end else if ($urandom_range(99) < 75) begin
        send_load(8'($urandom_range(255)));
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle ticks after reset keep the line low
    send_tick();
    send_tick();
    drain();

    // zero counts act as one tick; busy load is rejected; idle tick holds high
    set_timing_regs(0, 0);
    send_load(8'h00);
    send_load(8'hFF);
    finish_frame();
    send_tick();
    drain();

    // no idling, with a long receiver hold-off to fill the result buffer
    set_timing_regs(1, 3);
    hold_left <= HOLD_CYCLES;
    run_random(155);
    drain();

    send_idle_pct = 47;
    set_timing_regs(0, 2);
    run_random(155);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 47;
    set_timing_regs(0, 4);
    run_random(155);
    drain();

    send_idle_pct  = 35;
    recv_stall_pct = 35;
    set_timing_regs(0, 6);
    run_random(155);
    drain();

    // widest counts: a frame starts at full scale and counts down a few ticks; a second load is rejected
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timing_regs(65535, 65535);
    send_load(8'($urandom_range(255)));
    repeat (WIDE_TICKS) send_tick();
    send_load(8'($urandom_range(255)));

    drain();
    if (tracker.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
